>>> rtl/lcs_pkg.sv
// Shared types for the linear congruence solver.
// Holds datapath operation codes and the controller/datapath command and status structs.
package lcs_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_EUC_DIV = 3'd0,
    OP_EUC_MUL = 3'd1,
    OP_B_DIV   = 3'd2,
    OP_M_DIV   = 3'd3,
    OP_S_RED   = 3'd4,
    OP_Q_RED   = 3'd5,
    OP_X_MUL   = 3'd6
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  start_op;
    logic wr;
    op_t  wr_op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic r1_zero;
    logic p_zero;
    logic solvable;
  } status_t;

endpackage

>>> rtl/lcs_if.sv
// Valid/ready channel interfaces for the solver's request and response items.
// Stand-alone; width follows the interface parameter.
interface lcs_in_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] coefficient;
  logic [W-1:0] rhs;
  logic [W-1:0] modulus;
  modport source (output valid, coefficient, rhs, modulus, input ready);
  modport sink (input valid, coefficient, rhs, modulus, output ready);
endinterface

interface lcs_out_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] solution;
  logic         solvable;
  logic [W-1:0] divisor;
  modport source (output valid, solution, solvable, divisor, input ready);
  modport sink (input valid, solution, solvable, divisor, output ready);
endinterface

>>> rtl/lcs_divider.sv
// Restoring divider, one quotient bit per cycle.
// No package dependencies.
module lcs_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den_in,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  den;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;

  assign rem_sh = {rem, quo[W-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      busy <= (cnt != CW'(1));
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      den <= den_in;
      cnt <= CW'(W);
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo <= {quo[W-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end
endmodule

>>> rtl/lcs_modmul.sv
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// Expects both operands below the modulus; no package dependencies.
module lcs_modmul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x_in,
  input  logic [W-1:0] y_in,
  input  logic [W-1:0] m_in,
  output logic         done,
  output logic [W-1:0] acc
);
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic [W-1:0] m;
  logic         busy;
  logic [W:0]   sum_acc;
  logic [W:0]   sum_dbl;
  logic [W-1:0] acc_add;
  logic [W-1:0] x_dbl;

  assign sum_acc = {1'b0, acc} + {1'b0, x};
  assign sum_dbl = {1'b0, x} + {1'b0, x};
  assign acc_add = (sum_acc >= {1'b0, m}) ? W'(sum_acc - {1'b0, m}) : sum_acc[W-1:0];
  assign x_dbl   = (sum_dbl >= {1'b0, m}) ? W'(sum_dbl - {1'b0, m}) : sum_dbl[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && y == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      x   <= x_in;
      y   <= y_in;
      m   <= m_in;
    end else if (busy && y != '0) begin
      if (y[0]) begin
        acc <= acc_add;
      end
      x <= x_dbl;
      y <= y >> 1;
    end
  end
endmodule

>>> rtl/lcs_datapath.sv
// Operand registers, shared divider and modular multiplier of the solver.
// Depends on lcs_pkg, lcs_divider and lcs_modmul.
module lcs_datapath #(
  parameter int W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  lcs_pkg::cmd_t    cmd,
  output lcs_pkg::status_t status,
  input  logic [W-1:0]     coefficient,
  input  logic [W-1:0]     rhs,
  input  logic [W-1:0]     modulus,
  output logic [W-1:0]     solution,
  output logic             solvable,
  output logic [W-1:0]     divisor
);
  import lcs_pkg::*;

  logic [W-1:0] r0, r1, s0, s1, b, p, rn, m, qbd, xs, x;
  logic         solv;
  logic [W-1:0] div_num, div_den, div_quo, div_rem;
  logic [W-1:0] mul_x, mul_y, mul_m, mul_acc;
  logic         div_start, mul_start, div_done, mul_done;
  logic [W-1:0] q_red, s_next;

  // the divider holds its quotient, so take it straight from there
  assign q_red  = (div_quo >= p) ? div_quo - p : div_quo;
  assign s_next = (s0 >= mul_acc) ? s0 - mul_acc : s0 + (p - mul_acc);

  always_comb begin
    div_num   = r0;
    div_den   = r1;
    mul_x     = q_red;
    mul_y     = s1;
    mul_m     = p;
    div_start = 1'b0;
    mul_start = 1'b0;
    case (cmd.start_op)
      OP_EUC_DIV: div_start = cmd.start;
      OP_B_DIV: begin
        div_num   = b;
        div_den   = r0;
        div_start = cmd.start;
      end
      OP_M_DIV: begin
        div_num   = p;
        div_den   = r0;
        div_start = cmd.start;
      end
      OP_S_RED: begin
        // m is written on this same edge; use the held quotient
        div_num   = s0;
        div_den   = div_quo;
        div_start = cmd.start;
      end
      OP_Q_RED: begin
        div_num   = qbd;
        div_den   = m;
        div_start = cmd.start;
      end
      OP_EUC_MUL: mul_start = cmd.start;
      OP_X_MUL: begin
        // reduced rhs/gcd is still held in the divider remainder
        mul_x     = xs;
        mul_y     = div_rem;
        mul_m     = m;
        mul_start = cmd.start;
      end
      default: ;
    endcase
  end

  lcs_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den_in(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  lcs_modmul #(.W(W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .x_in(mul_x), .y_in(mul_y), .m_in(mul_m),
    .done(mul_done), .acc(mul_acc)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0   <= coefficient;
      r1   <= modulus;
      s0   <= (modulus == W'(1)) ? '0 : W'(1);
      s1   <= '0;
      b    <= rhs;
      p    <= modulus;
      x    <= '0;
      solv <= 1'b0;
    end else if (cmd.wr) begin
      case (cmd.wr_op)
        OP_EUC_DIV: begin
          rn <= div_rem;
        end
        OP_EUC_MUL: begin
          r0 <= r1;
          r1 <= rn;
          s0 <= s1;
          s1 <= s_next;
        end
        OP_B_DIV: begin
          qbd  <= div_quo;
          solv <= (div_rem == '0);
        end
        OP_M_DIV: m   <= div_quo;
        OP_S_RED: xs  <= div_rem;
        OP_Q_RED: qbd <= div_rem;
        OP_X_MUL: x   <= mul_acc;
        default: ;
      endcase
    end
  end

  // result register; holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      solution <= x;
      solvable <= solv;
      divisor  <= r0;
    end
  end

  assign status.div_done = div_done;
  assign status.mul_done = mul_done;
  assign status.r1_zero  = (r1 == '0);
  assign status.p_zero   = (p == '0);
  assign status.solvable = solv;
endmodule

>>> rtl/lcs_ctrl.sv
// Sequencing state machine of the solver: Euclid steps, then the final reductions.
// Depends on lcs_pkg.
module lcs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lcs_pkg::status_t status,
  output lcs_pkg::cmd_t    cmd
);
  import lcs_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_EUC_CHK = 10'b00_0000_0010,
    S_EUC_DIV = 10'b00_0000_0100,
    S_EUC_MUL = 10'b00_0000_1000,
    S_B_DIV   = 10'b00_0001_0000,
    S_M_DIV   = 10'b00_0010_0000,
    S_S_RED   = 10'b00_0100_0000,
    S_Q_RED   = 10'b00_1000_0000,
    S_X_MUL   = 10'b01_0000_0000,
    S_FIN     = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.start_op = OP_EUC_DIV;
    cmd.wr_op    = OP_EUC_DIV;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EUC_CHK;
        end
      end
      S_EUC_CHK: begin
        cmd.start = !status.r1_zero || !status.p_zero;
        if (!status.r1_zero) begin
          state_next = S_EUC_DIV;
        end else if (status.p_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.start_op = OP_B_DIV;
          state_next   = S_B_DIV;
        end
      end
      S_EUC_DIV: begin
        if (status.div_done) begin
          cmd.wr       = 1'b1;
          cmd.start    = 1'b1;
          cmd.start_op = OP_EUC_MUL;
          state_next   = S_EUC_MUL;
        end
      end
      S_EUC_MUL: begin
        if (status.mul_done) begin
          cmd.wr     = 1'b1;
          cmd.wr_op  = OP_EUC_MUL;
          state_next = S_EUC_CHK;
        end
      end
      S_B_DIV: begin
        if (status.div_done) begin
          cmd.wr    = 1'b1;
          cmd.wr_op = OP_B_DIV;
          state_next = S_M_DIV;
        end
      end
      S_M_DIV: begin
        // drop straight to the result when gcd does not divide rhs
        if (!status.solvable) begin
          state_next = S_FIN;
        end else begin
          cmd.start    = 1'b1;
          cmd.start_op = OP_M_DIV;
          state_next   = S_S_RED;
        end
      end
      S_S_RED: begin
        if (status.div_done) begin
          cmd.wr       = 1'b1;
          cmd.wr_op    = OP_M_DIV;
          cmd.start    = 1'b1;
          cmd.start_op = OP_S_RED;
          state_next   = S_Q_RED;
        end
      end
      S_Q_RED: begin
        if (status.div_done) begin
          cmd.wr       = 1'b1;
          cmd.wr_op    = OP_S_RED;
          cmd.start    = 1'b1;
          cmd.start_op = OP_Q_RED;
          state_next   = S_X_MUL;
        end
      end
      S_X_MUL: begin
        if (status.div_done) begin
          cmd.wr       = 1'b1;
          cmd.wr_op    = OP_Q_RED;
          cmd.start    = 1'b1;
          cmd.start_op = OP_X_MUL;
        end
        if (status.mul_done) begin
          cmd.wr     = 1'b1;
          cmd.wr_op  = OP_X_MUL;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

>>> rtl/linear_congruence_solver_core.sv
// Linear congruence solver: coefficient*x = rhs (mod modulus) by extended Euclid.
// Top level; depends on lcs_pkg, lcs_if, lcs_ctrl and lcs_datapath.
//
// Channels: req carries coefficient, rhs and modulus; rsp carries solution,
// solvable and divisor. Both are valid/ready; an item moves when both are high.
// One item is worked at a time; req.ready is high only while the solver is idle,
// and it is high even while an earlier result still waits on rsp.
// Each Euclid quotient step takes a check, a division in the shared restoring
// divider and a multiply in the shift-and-add modular multiplier. The tail
// takes a check, at most four divisions and one modular multiply; a zero
// modulus goes straight from the check to the result. The divider and
// multiplier set the run time.
// Reset clears the controller and drops rsp.valid. A stalled receiver holds the
// result in the output register; the next item may be accepted and worked, and
// its result waits until the held one is taken.
module linear_congruence_solver_core #(
  parameter int OPERAND_WIDTH = lcs_pkg::OPERAND_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  lcs_in_if.sink   req,
  lcs_out_if.source rsp
);
  import lcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  lcs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .status(status), .cmd(cmd)
  );

  lcs_datapath #(.W(OPERAND_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .coefficient(req.coefficient), .rhs(req.rhs), .modulus(req.modulus),
    .solution(rsp.solution), .solvable(rsp.solvable), .divisor(rsp.divisor)
  );
endmodule
